/* src/jsonb_scalar_element_validator_defines.svh */
// Assertion macros shared by the scalar element validator.
`ifndef JSONB_SCALAR_ELEMENT_VALIDATOR_DEFINES_SVH
`define JSONB_SCALAR_ELEMENT_VALIDATOR_DEFINES_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define JSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define JSV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/jsv_pkg.sv */
// Types, codes and per-character check functions of the scalar element validator.
`timescale 1ns / 1ps

package jsv_pkg;

  typedef logic [7:0]  data_byte_t;
  typedef logic [3:0]  tag_t;
  typedef logic [63:0] length_t;
  typedef logic [6:0]  flags_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_VALID     = 4'd0,
    ST_EMPTY     = 4'd1,
    ST_SHORT     = 4'd2,
    ST_LIT_LEN   = 4'd3,
    ST_BAD_INT   = 4'd4,
    ST_BAD_HEX   = 4'd5,
    ST_BAD_FLOAT = 4'd6,
    ST_BAD_FLT5  = 4'd7,
    ST_UNSUPP    = 4'd8
  } status_e;

  // Element tags that are checked; all others are unsupported.
  localparam tag_t TAG_NULL   = 4'd0;
  localparam tag_t TAG_TRUE   = 4'd1;
  localparam tag_t TAG_FALSE  = 4'd2;
  localparam tag_t TAG_INT    = 4'd3;
  localparam tag_t TAG_HEX    = 4'd4;
  localparam tag_t TAG_FLOAT  = 4'd5;
  localparam tag_t TAG_FLOAT5 = 4'd6;

  // Header size codes that select a number of length bytes.
  localparam logic [3:0] SZ_FIRST = 4'd12;
  localparam logic [3:0] SZ_ONE   = 4'd12;
  localparam logic [3:0] SZ_TWO   = 4'd13;
  localparam logic [3:0] SZ_FOUR  = 4'd14;

  // Bit positions in the character-check flags.
  localparam int FL_SIGN      = 0;
  localparam int FL_DOT       = 1;
  localparam int FL_DIGIT     = 2;
  localparam int FL_E         = 3;
  localparam int FL_FIRSTZERO = 4;
  localparam int FL_X         = 5;
  localparam int FL_LEADZERO  = 6;

  // Characters of interest.
  localparam data_byte_t CH_PLUS  = 8'h2b;
  localparam data_byte_t CH_MINUS = 8'h2d;
  localparam data_byte_t CH_DOT   = 8'h2e;
  localparam data_byte_t CH_ZERO  = 8'h30;
  localparam data_byte_t CH_NINE  = 8'h39;
  localparam data_byte_t CH_UC_A  = 8'h41;
  localparam data_byte_t CH_UC_E  = 8'h45;
  localparam data_byte_t CH_UC_F  = 8'h46;
  localparam data_byte_t CH_UC_X  = 8'h58;
  localparam data_byte_t CH_LC_A  = 8'h61;
  localparam data_byte_t CH_LC_E  = 8'h65;
  localparam data_byte_t CH_LC_F  = 8'h66;
  localparam data_byte_t CH_LC_X  = 8'h78;
  localparam data_byte_t CH_LOW   = 8'd32;
  localparam data_byte_t CH_HIGH  = 8'd127;

  // Outcome of one character check.
  typedef struct packed {
    logic   ok;
    flags_t flags;
  } check_t;

  function automatic logic is_dec(data_byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex_letter(data_byte_t c);
    return ((c >= CH_LC_A) && (c <= CH_LC_F)) || ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

  // Decimal integer: optional leading minus, digits, no leading zero.
  function automatic check_t take_int(data_byte_t c, flags_t f);
    check_t r;
    r.ok    = 1'b1;
    r.flags = f;
    if (c == CH_MINUS) begin
      if (f[FL_SIGN] || f[FL_DIGIT]) r.ok = 1'b0;
      r.flags[FL_SIGN] = 1'b1;
    end else if (is_dec(c)) begin
      if (f[FL_DIGIT] && f[FL_FIRSTZERO]) r.ok = 1'b0;
      if (!f[FL_DIGIT] && (c == CH_ZERO)) r.flags[FL_FIRSTZERO] = 1'b1;
      r.flags[FL_DIGIT] = 1'b1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Hex integer: optional minus, then 0x and hex digits.
  function automatic check_t take_hex(data_byte_t c, flags_t f);
    check_t r;
    r.ok    = 1'b1;
    r.flags = f;
    if (c == CH_MINUS) begin
      if (f[FL_SIGN] || f[FL_X] || f[FL_LEADZERO] || f[FL_DIGIT]) r.ok = 1'b0;
      r.flags[FL_SIGN] = 1'b1;
    end else if (is_dec(c) || is_hex_letter(c)) begin
      if ((c == CH_ZERO) && !f[FL_X] && !f[FL_LEADZERO]) begin
        r.flags[FL_LEADZERO] = 1'b1;
      end else if (!f[FL_X]) begin
        r.ok = 1'b0;
      end else begin
        r.flags[FL_DIGIT] = 1'b1;
      end
    end else if ((c == CH_LC_X) || (c == CH_UC_X)) begin
      if (f[FL_X] || !f[FL_LEADZERO]) r.ok = 1'b0;
      r.flags[FL_X] = 1'b1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Float: strict form needs a digit before the dot; relaxed form does not.
  function automatic check_t take_float(data_byte_t c, flags_t f, logic relaxed);
    check_t r;
    r.ok    = 1'b1;
    r.flags = f;
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      if ((c == CH_PLUS) && !f[FL_E]) r.ok = 1'b0;
      if (f[FL_SIGN] || f[FL_DIGIT] || f[FL_DOT]) r.ok = 1'b0;
      r.flags[FL_SIGN] = 1'b1;
    end else if (c == CH_DOT) begin
      if (f[FL_E] || f[FL_DOT]) r.ok = 1'b0;
      if (!relaxed) begin
        if (!f[FL_DIGIT]) r.ok = 1'b0;
        r.flags[FL_DIGIT] = 1'b0;
      end
      r.flags[FL_DOT] = 1'b1;
    end else if (is_dec(c)) begin
      if (!(f[FL_E] || f[FL_DOT])) begin
        if (f[FL_DIGIT] && f[FL_FIRSTZERO]) r.ok = 1'b0;
        if (!f[FL_DIGIT] && (c == CH_ZERO)) r.flags[FL_FIRSTZERO] = 1'b1;
      end
      r.flags[FL_DIGIT] = 1'b1;
    end else if ((c == CH_LC_E) || (c == CH_UC_E)) begin
      if (!f[FL_DIGIT] || f[FL_E]) r.ok = 1'b0;
      r.flags[FL_DIGIT] = 1'b0;
      r.flags[FL_SIGN]  = 1'b0;
      r.flags[FL_DOT]   = 1'b0;
      r.flags[FL_E]     = 1'b1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* src/jsv_in_if.sv */
// Input channel: one buffer byte and its end-of-buffer mark per transaction.
`timescale 1ns / 1ps

interface jsv_in_if import jsv_pkg::*; ();
  logic       valid;
  logic       ready;
  data_byte_t data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

/* src/jsv_out_if.sv */
// Output channel: one element status with its tag and length per transaction.
`timescale 1ns / 1ps

interface jsv_out_if import jsv_pkg::*; ();
  logic    valid;
  logic    ready;
  status_e status;
  tag_t    element_tag;
  length_t payload_length;

  modport source (output valid, output status, output element_tag,
                  output payload_length, input ready);
  modport sink   (input valid, input status, input element_tag,
                  input payload_length, output ready);
endinterface

/* src/jsonb_scalar_element_validator.sv */
// Streaming validator for one scalar element of a binary JSON buffer.
`timescale 1ns / 1ps

// The block takes one buffer byte per cycle and keeps doing so while a
// finished status waits in its output register, as long as the consumer
// takes that status in the same cycle or the register is empty. A status
// appears in the output register in the cycle after the byte that completes
// the element, or after the end-of-buffer byte of a buffer that ends
// short. Each byte is handled by the header decoder, the big-endian length
// shifter and the per-character checker; the widest path is the 64-bit
// payload byte count and its compare with the decoded length.
// Bytes after a status are dropped until the end-of-buffer mark, which
// re-arms the block for the next element. There is no reset sweep.
`include "jsonb_scalar_element_validator_defines.svh"

module jsonb_scalar_element_validator import jsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsv_in_if.sink    in_i,
  jsv_out_if.source out_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  phase_e     phase_q, phase_d;
  tag_t       tag_q, tag_d;
  logic [3:0] left_q, left_d;
  length_t    len_q, len_d;
  length_t    seen_q, seen_d;
  flags_t     flags_q, flags_d;
  logic       failed_q, failed_d;

  logic       out_valid_q;
  status_e    out_status_q;
  tag_t       out_tag_q;
  length_t    out_len_q;

  logic       in_fire;
  logic       complete;
  logic       emit;
  status_e    status_d;
  status_e    final_status;
  logic [3:0] nib;
  check_t     chk;

  // Accept a byte whenever the output register is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign nib        = in_i.data_byte[7:4];

  // Character check for the held tag.
  always_comb begin
    chk.ok    = 1'b1;
    chk.flags = flags_q;
    case (tag_q)
      TAG_INT:    chk = take_int(in_i.data_byte, flags_q);
      TAG_HEX:    chk = take_hex(in_i.data_byte, flags_q);
      TAG_FLOAT:  chk = take_float(in_i.data_byte, flags_q, 1'b0);
      TAG_FLOAT5: chk = take_float(in_i.data_byte, flags_q, 1'b1);
      default:    chk.ok = 1'b1;
    endcase
  end

  // Next element state for the accepted byte.
  always_comb begin
    tag_d    = tag_q;
    left_d   = left_q;
    len_d    = len_q;
    seen_d   = seen_q;
    flags_d  = flags_q;
    failed_d = failed_q;
    phase_d  = phase_q;
    complete = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        tag_d    = in_i.data_byte[3:0];
        seen_d   = '0;
        flags_d  = '0;
        failed_d = 1'b0;
        left_d   = '0;
        len_d    = '0;
        if (nib < SZ_FIRST) begin
          len_d = {60'd0, nib};
          if (nib == 4'd0) begin
            complete = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end else begin
          case (nib)
            SZ_ONE:  left_d = 4'd1;
            SZ_TWO:  left_d = 4'd2;
            SZ_FOUR: left_d = 4'd4;
            default: left_d = 4'd8;
          endcase
          phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_d  = {len_q[55:0], in_i.data_byte};
        left_d = (left_q != 4'd0) ? left_q - 4'd1 : left_q;
        if (left_d == 4'd0) begin
          if (len_d == '0) begin
            complete = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (!failed_q) begin
          if ((in_i.data_byte < CH_LOW) || (in_i.data_byte > CH_HIGH)) begin
            failed_d = 1'b1;
          end else begin
            flags_d  = chk.flags;
            failed_d = !chk.ok;
          end
        end
        seen_d = seen_q + 64'd1;
        if (seen_d >= len_q) complete = 1'b1;
      end
      default: begin
        complete = 1'b0;
      end
    endcase
    if (phase_q != PH_DONE) begin
      if (complete) begin
        phase_d = in_i.end_of_buffer ? PH_HEADER : PH_DONE;
      end else if (in_i.end_of_buffer) begin
        phase_d = PH_HEADER;
      end
    end else if (in_i.end_of_buffer) begin
      phase_d = PH_HEADER;
    end
  end

  // Status of a completed element.
  always_comb begin
    logic good;
    good = !failed_d && flags_d[FL_DIGIT];
    case (tag_d)
      TAG_NULL, TAG_TRUE, TAG_FALSE: final_status = (len_d != '0) ? ST_LIT_LEN : ST_VALID;
      TAG_INT:    final_status = good ? ST_VALID : ST_BAD_INT;
      TAG_HEX:    final_status = good ? ST_VALID : ST_BAD_HEX;
      TAG_FLOAT:  final_status = good ? ST_VALID : ST_BAD_FLOAT;
      TAG_FLOAT5: final_status = good ? ST_VALID : ST_BAD_FLT5;
      default:    final_status = ST_UNSUPP;
    endcase
  end

  assign emit     = (phase_q != PH_DONE) && (complete || in_i.end_of_buffer);
  assign status_d = complete ? final_status : ST_SHORT;

  // Element state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      tag_q        <= '0;
      left_q       <= '0;
      len_q        <= '0;
      seen_q       <= '0;
      flags_q      <= '0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_VALID;
      out_tag_q    <= '0;
      out_len_q    <= '0;
    end else begin
      if (in_fire) begin
        phase_q  <= phase_d;
        tag_q    <= tag_d;
        left_q   <= left_d;
        len_q    <= len_d;
        seen_q   <= seen_d;
        flags_q  <= flags_d;
        failed_q <= failed_d;
      end
      if (in_fire && emit) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_d;
        out_tag_q    <= tag_d;
        out_len_q    <= len_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.element_tag    = out_tag_q;
  assign out_o.payload_length = out_len_q;

  // Consistency checks on the element state.
  `JSV_ASSERT(a_length_pending, (phase_q == PH_LENGTH) |-> (left_q != 4'd0), "length phase with no bytes left")
  `JSV_ASSERT(a_payload_count, (phase_q == PH_PAYLOAD) |-> (seen_q < len_q), "payload count reached length")
  `JSV_ASSERT_NEVER(a_done_silent, in_fire && (phase_q == PH_DONE) && emit, "result after element end")
  `JSV_ASSERT(a_short_on_end, (in_fire && emit && (status_d == ST_SHORT)) |-> in_i.end_of_buffer, "short status without end of buffer")

endmodule

/* verif/jsv_element_checker.sv */
// Checker that predicts and compares the element status stream of the validator.
`timescale 1ns / 1ps

module jsv_element_checker import jsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsv_in_if           in_mon,
  jsv_out_if          out_mon,
  output int unsigned mismatch_count_o,
  output int unsigned awaiting_count_o
);

  // Where the predicted scan of the current buffer stands.
  typedef enum logic [1:0] {
    AT_HEADER,
    AT_LENGTH,
    AT_PAYLOAD,
    AT_TRAILING
  } scan_phase_e;

  typedef struct packed {
    status_e status;
    tag_t    tag;
    length_t length;
  } element_result_t;

  localparam int unsigned PRINT_LIMIT = 50;

  scan_phase_e     scan_phase;
  tag_t            cur_tag;
  logic [3:0]      len_bytes_left;
  length_t         decl_len;
  length_t         body_count;
  flags_t          char_flags;
  logic            char_failed;
  int unsigned     mismatch_total;
  element_result_t pending_results_q[$];

  function automatic logic is_digit(data_byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decimal integer character; updates the running flags.
  function automatic logic int_char(data_byte_t c);
    if (c == CH_MINUS) begin
      if (char_flags[FL_SIGN] || char_flags[FL_DIGIT]) return 1'b0;
      char_flags[FL_SIGN] = 1'b1;
      return 1'b1;
    end
    if (is_digit(c)) begin
      if (char_flags[FL_DIGIT] && char_flags[FL_FIRSTZERO]) return 1'b0;
      if (!char_flags[FL_DIGIT] && (c == CH_ZERO)) char_flags[FL_FIRSTZERO] = 1'b1;
      char_flags[FL_DIGIT] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Hex integer character: an optional minus, a zero, an x, then hex digits.
  function automatic logic hex_char(data_byte_t c);
    logic hex_digit;
    hex_digit = is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
                ((c >= CH_UC_A) && (c <= CH_UC_F));
    if (c == CH_MINUS) begin
      if (char_flags[FL_SIGN] || char_flags[FL_X] || char_flags[FL_LEADZERO] ||
          char_flags[FL_DIGIT]) return 1'b0;
      char_flags[FL_SIGN] = 1'b1;
      return 1'b1;
    end
    if (hex_digit) begin
      if ((c == CH_ZERO) && !char_flags[FL_X] && !char_flags[FL_LEADZERO]) begin
        char_flags[FL_LEADZERO] = 1'b1;
        return 1'b1;
      end
      if (!char_flags[FL_X]) return 1'b0;
      char_flags[FL_DIGIT] = 1'b1;
      return 1'b1;
    end
    if ((c == CH_LC_X) || (c == CH_UC_X)) begin
      if (char_flags[FL_X] || !char_flags[FL_LEADZERO]) return 1'b0;
      char_flags[FL_X] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Float character; the relaxed form accepts a dot with no digit before it.
  function automatic logic float_char(data_byte_t c, logic relaxed);
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      if ((c == CH_PLUS) && !char_flags[FL_E]) return 1'b0;
      if (char_flags[FL_SIGN] || char_flags[FL_DIGIT] || char_flags[FL_DOT]) return 1'b0;
      char_flags[FL_SIGN] = 1'b1;
      return 1'b1;
    end
    if (c == CH_DOT) begin
      if (char_flags[FL_E] || char_flags[FL_DOT]) return 1'b0;
      if (!relaxed) begin
        if (!char_flags[FL_DIGIT]) return 1'b0;
        char_flags[FL_DIGIT] = 1'b0;
      end
      char_flags[FL_DOT] = 1'b1;
      return 1'b1;
    end
    if (is_digit(c)) begin
      // Leading-zero rule applies to the integer part only.
      if (char_flags[FL_E] || char_flags[FL_DOT]) begin
        char_flags[FL_DIGIT] = 1'b1;
        return 1'b1;
      end
      if (char_flags[FL_DIGIT] && char_flags[FL_FIRSTZERO]) return 1'b0;
      if (!char_flags[FL_DIGIT] && (c == CH_ZERO)) char_flags[FL_FIRSTZERO] = 1'b1;
      char_flags[FL_DIGIT] = 1'b1;
      return 1'b1;
    end
    if ((c == CH_LC_E) || (c == CH_UC_E)) begin
      if (!char_flags[FL_DIGIT] || char_flags[FL_E]) return 1'b0;
      char_flags[FL_DIGIT] = 1'b0;
      char_flags[FL_SIGN]  = 1'b0;
      char_flags[FL_DOT]   = 1'b0;
      char_flags[FL_E]     = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Status of an element whose payload has fully arrived.
  function automatic status_e element_status();
    logic good;
    good = !char_failed && char_flags[FL_DIGIT];
    case (cur_tag)
      TAG_NULL, TAG_TRUE, TAG_FALSE: return (decl_len != '0) ? ST_LIT_LEN : ST_VALID;
      TAG_INT:    return good ? ST_VALID : ST_BAD_INT;
      TAG_HEX:    return good ? ST_VALID : ST_BAD_HEX;
      TAG_FLOAT:  return good ? ST_VALID : ST_BAD_FLOAT;
      TAG_FLOAT5: return good ? ST_VALID : ST_BAD_FLT5;
      default:    return ST_UNSUPP;
    endcase
  endfunction

  // One payload character; once an element has failed, it stays failed.
  task automatic check_payload_char(input data_byte_t c);
    logic ok;
    ok = 1'b1;
    if (!char_failed) begin
      if ((c < CH_LOW) || (c > CH_HIGH)) begin
        ok = 1'b0;
      end else begin
        case (cur_tag)
          TAG_INT:    ok = int_char(c);
          TAG_HEX:    ok = hex_char(c);
          TAG_FLOAT:  ok = float_char(c, 1'b0);
          TAG_FLOAT5: ok = float_char(c, 1'b1);
          default:    ok = 1'b1;
        endcase
      end
      if (!ok) char_failed = 1'b1;
    end
  endtask

  // Advances the predicted scan by one accepted byte and queues any status it causes.
  task automatic predict_byte(input data_byte_t b, input logic last);
    logic            done;
    element_result_t res;
    done = 1'b0;
    if (scan_phase == AT_TRAILING) begin
      if (last) scan_phase = AT_HEADER;
    end else begin
      if (scan_phase == AT_HEADER) begin
        cur_tag        = b[3:0];
        decl_len       = '0;
        body_count     = '0;
        char_flags     = '0;
        char_failed    = 1'b0;
        len_bytes_left = 4'd0;
        if (b[7:4] < SZ_FIRST) begin
          decl_len = length_t'(b[7:4]);
          if (b[7:4] == 4'd0) done = 1'b1;
          else scan_phase = AT_PAYLOAD;
        end else begin
          case (b[7:4])
            SZ_ONE:  len_bytes_left = 4'd1;
            SZ_TWO:  len_bytes_left = 4'd2;
            SZ_FOUR: len_bytes_left = 4'd4;
            default: len_bytes_left = 4'd8;
          endcase
          scan_phase = AT_LENGTH;
        end
      end else if (scan_phase == AT_LENGTH) begin
        decl_len = {decl_len[55:0], b};
        if (len_bytes_left != 4'd0) len_bytes_left--;
        if (len_bytes_left == 4'd0) begin
          if (decl_len == '0) done = 1'b1;
          else scan_phase = AT_PAYLOAD;
        end
      end else begin
        check_payload_char(b);
        body_count++;
        if (body_count >= decl_len) done = 1'b1;
      end

      // A completed element wins over the end mark; otherwise the end mark means short.
      res.tag    = cur_tag;
      res.length = decl_len;
      if (done) begin
        res.status = element_status();
        pending_results_q.push_back(res);
        scan_phase = last ? AT_HEADER : AT_TRAILING;
      end else if (last) begin
        res.status = ST_SHORT;
        pending_results_q.push_back(res);
        scan_phase = AT_HEADER;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_total++;
    if (mismatch_total <= PRINT_LIMIT) $display("%0t: status mismatch: %s", $time, what);
  endtask

  // Predicts on every accepted byte and compares every accepted status.
  always @(posedge clk_i or negedge rst_ni) begin : track
    element_result_t want;
    if (!rst_ni) begin
      scan_phase     = AT_HEADER;
      cur_tag        = '0;
      len_bytes_left = 4'd0;
      decl_len       = '0;
      body_count     = '0;
      char_flags     = '0;
      char_failed    = 1'b0;
      mismatch_total = 0;
      pending_results_q.delete();
      mismatch_count_o <= 0;
      awaiting_count_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_byte(in_mon.data_byte, in_mon.end_of_buffer);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results_q.size() == 0) begin
          report_mismatch($sformatf("status %0d tag %0d length %0d with none expected",
                                    out_mon.status, out_mon.element_tag,
                                    out_mon.payload_length));
        end else begin
          want = pending_results_q.pop_front();
          if (out_mon.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_mon.status, want.status));
          end
          if (out_mon.element_tag !== want.tag) begin
            report_mismatch($sformatf("tag %0d, expected %0d",
                                      out_mon.element_tag, want.tag));
          end
          if (out_mon.payload_length !== want.length) begin
            report_mismatch($sformatf("length 0x%0h, expected 0x%0h",
                                      out_mon.payload_length, want.length));
          end
        end
      end
      mismatch_count_o <= mismatch_total;
      awaiting_count_o <= pending_results_q.size();
    end
  end

endmodule

/* verif/jsonb_scalar_element_validator_tb.sv */
// Testbench top: stimulus, flow control and verdict for the scalar element validator.
`timescale 1ns / 1ps

module jsonb_scalar_element_validator_tb;
  import jsv_pkg::*;

  localparam int unsigned RANDOM_BYTES = 550;
  localparam logic [3:0]  SZ_EIGHT     = 4'd15;
  localparam tag_t        TAG_TEXT     = 4'd7;
  localparam tag_t        TAG_LAST     = 4'd15;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rx_ready_q = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned element_bytes = 0;
  int unsigned mismatch_count;
  int unsigned awaiting_count;
  data_byte_t  body_q[$];

  jsv_in_if  in_bus();
  jsv_out_if out_bus();

  jsonb_scalar_element_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  jsv_element_checker status_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .mismatch_count_o (mismatch_count),
    .awaiting_count_o (awaiting_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The consumer stalls at random according to the current stall rate.
  assign out_bus.ready = rx_ready_q;
  always @(posedge clk_i) begin
    rx_ready_q <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the flow hangs.
  initial begin
    #5_000_000;
    $display("jsonb_scalar_element_validator_tb: done, errors");
    $finish;
  end

  // Offers one byte, with random idle cycles first, and holds it until accepted.
  task automatic send_byte(input data_byte_t value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= value;
    in_bus.end_of_buffer <= last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic add_digits(input int unsigned count);
    repeat (count) body_q.push_back(CH_ZERO + data_byte_t'($urandom_range(9)));
  endtask

  // Integer part: a lone zero or a nonzero digit followed by up to five more digits.
  task automatic add_int_part();
    if ($urandom_range(3) == 0) begin
      body_q.push_back(CH_ZERO);
    end else begin
      body_q.push_back(CH_ZERO + data_byte_t'($urandom_range(9, 1)));
      add_digits($urandom_range(5));
    end
  endtask

  // Builds a mostly well-formed number for the given tag, sometimes spoiled.
  task automatic make_numeric(input tag_t tag);
    logic        lead_dot;
    int unsigned pos;
    body_q.delete();
    if ($urandom_range(2) == 0) body_q.push_back(CH_MINUS);
    case (tag)
      TAG_INT: add_int_part();
      TAG_HEX: begin
        body_q.push_back(CH_ZERO);
        body_q.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(2))
            0:       body_q.push_back(CH_ZERO + data_byte_t'($urandom_range(9)));
            1:       body_q.push_back(CH_LC_A + data_byte_t'($urandom_range(5)));
            default: body_q.push_back(CH_UC_A + data_byte_t'($urandom_range(5)));
          endcase
        end
      end
      default: begin
        // Only the relaxed float may open with the dot.
        lead_dot = (tag == TAG_FLOAT5) && ($urandom_range(3) == 0);
        if (!lead_dot) add_int_part();
        if (lead_dot || $urandom_range(1)) begin
          body_q.push_back(CH_DOT);
          add_digits($urandom_range(4, 1));
        end
        if ($urandom_range(2) == 0) begin
          body_q.push_back($urandom_range(1) ? CH_LC_E : CH_UC_E);
          case ($urandom_range(2))
            0:       body_q.push_back(CH_PLUS);
            1:       body_q.push_back(CH_MINUS);
            default: ;
          endcase
          add_digits($urandom_range(3, 1));
        end
      end
    endcase

    // Spoil one character now and then, with either a tricky or a random byte.
    if ($urandom_range(4) == 0) begin
      pos = $urandom_range(body_q.size() - 1);
      case ($urandom_range(7))
        0:       body_q[pos] = CH_PLUS;
        1:       body_q[pos] = CH_MINUS;
        2:       body_q[pos] = CH_DOT;
        3:       body_q[pos] = CH_LC_E;
        4:       body_q[pos] = CH_UC_X;
        5:       body_q[pos] = CH_ZERO;
        6:       body_q[pos] = CH_LC_A;
        default: body_q[pos] = data_byte_t'($urandom_range(255));
      endcase
    end
    if ($urandom_range(19) == 0) body_q.delete();
  endtask

  // Frames body_q under a header and sends it as one buffer, whole, cut short or
  // followed by trailing bytes.
  task automatic send_element(input tag_t tag);
    data_byte_t  frame_q[$];
    int unsigned len, width, keep, trail, i;
    logic [3:0]  code;
    len = body_q.size();
    if ((len <= 11) && ($urandom_range(3) != 0)) begin
      frame_q.push_back({4'(len), tag});
    end else begin
      code = 4'($urandom_range(15, 12));
      case (code)
        SZ_ONE:  width = 1;
        SZ_TWO:  width = 2;
        SZ_FOUR: width = 4;
        default: width = 8;
      endcase
      frame_q.push_back({code, tag});
      for (i = width; i > 0; i--) frame_q.push_back(data_byte_t'(len >> (8 * (i - 1))));
    end
    foreach (body_q[j]) frame_q.push_back(body_q[j]);

    keep  = frame_q.size();
    trail = 0;
    case ($urandom_range(9))
      0, 1:    if (keep > 1) keep = $urandom_range(keep - 1, 1);
      2, 3:    trail = $urandom_range(3, 1);
      default: ;
    endcase
    for (i = 0; i < keep; i++) send_byte(frame_q[i], (i == keep - 1) && (trail == 0));
    element_bytes += keep;
    for (i = 0; i < trail; i++) send_byte(data_byte_t'($urandom_range(255)), i == trail - 1);
  endtask

  initial begin : stimulus
    int unsigned kind, n, i;
    tag_t        tag;
    logic [3:0]  code;

    rst_ni               <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.data_byte     <= '0;
    in_bus.end_of_buffer <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: one short buffer per special case.
    idle_pct  = 12;
    stall_pct = 12;
    // Null with empty payload, ending the buffer.
    send_byte({4'd0, TAG_NULL}, 1'b1);
    // True, then trailing bytes that are dropped until the end mark.
    send_byte({4'd0, TAG_TRUE}, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    // False carrying a payload byte.
    send_byte({4'd1, TAG_FALSE}, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte({4'd2, TAG_INT}, 1'b0);
    send_byte(CH_MINUS, 1'b0);
    send_byte(CH_NINE, 1'b1);
    // Hex integer with a one-byte length field.
    send_byte({SZ_ONE, TAG_HEX}, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(CH_ZERO, 1'b0);
    send_byte(CH_UC_X, 1'b0);
    send_byte(CH_UC_F, 1'b1);
    // Character above the printable range.
    send_byte({4'd1, TAG_FLOAT}, 1'b0);
    send_byte(8'h80, 1'b1);
    // Relaxed float opening with a dot.
    send_byte({4'd2, TAG_FLOAT5}, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_ZERO + 8'd5, 1'b1);
    // Buffer ends inside an eight-byte length field.
    send_byte({SZ_EIGHT, TAG_LAST}, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b1);
    // Unsupported tag.
    send_byte({4'd1, TAG_LAST}, 1'b0);
    send_byte(8'h7f, 1'b1);
    // Largest inline length, buffer ends inside the payload.
    send_byte({4'd11, TAG_INT}, 1'b0);
    send_byte(CH_ZERO + 8'd1, 1'b1);

    // Random part, in flow-control phases.
    while (element_bytes < RANDOM_BYTES) begin
      case (element_bytes * 4 / RANDOM_BYTES)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      kind = $urandom_range(99);
      if (kind < 60) begin
        tag = TAG_INT + tag_t'($urandom_range(3));
        make_numeric(tag);
        send_element(tag);
      end else if (kind < 75) begin
        // Literal, mostly empty as it should be.
        tag = tag_t'($urandom_range(2));
        body_q.delete();
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(3, 1)) body_q.push_back(data_byte_t'($urandom_range(255)));
        end
        send_element(tag);
      end else if (kind < 85) begin
        tag = tag_t'($urandom_range(TAG_LAST, TAG_TEXT));
        body_q.delete();
        repeat ($urandom_range(14)) body_q.push_back(data_byte_t'($urandom_range(255)));
        send_element(tag);
      end else if (kind < 93) begin
        // Random wide length field; the buffer nearly always ends short.
        tag  = tag_t'($urandom_range(15));
        code = $urandom_range(1) ? SZ_FOUR : SZ_EIGHT;
        n    = (code == SZ_FOUR) ? 4 : 8;
        send_byte({code, tag}, 1'b0);
        for (i = 0; i < n; i++) send_byte(data_byte_t'($urandom_range(255)), 1'b0);
        n += 1;
        send_byte(CH_ZERO + data_byte_t'($urandom_range(9)), 1'b1);
        element_bytes += n + 1;
      end else begin
        // Noise buffer with random end marks.
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) begin
          send_byte(data_byte_t'($urandom_range(255)), (i == n - 1) || ($urandom_range(5) == 0));
        end
        element_bytes += n;
      end
    end
    in_bus.valid <= 1'b0;

    // Let the last transaction reach the checker, drain, then allow for the
    // output register latency.
    repeat (2) @(posedge clk_i);
    while (awaiting_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if ((mismatch_count == 0) && (awaiting_count == 0)) begin
      $display("jsonb_scalar_element_validator_tb: done, clean");
    end else begin
      $display("jsonb_scalar_element_validator_tb: done, errors");
    end
    $finish;
  end

endmodule
